FILE: hw/rtl/boxov_pkg.sv
// ----------------------------------------------------------------------------
// Box overlap search package
// Shared constants, command and status types, and fixed-point helpers for the
// box overlap first-hit search block.
// ----------------------------------------------------------------------------
package boxov_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SLOT_W    = 6;
    localparam int CMP_W     = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 8;
    localparam int Q_W       = 18;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_QPOS  = 2'd1;
    localparam logic [1:0] MODE_QBND  = 2'd2;

    typedef struct packed {
        logic capture;
        logic wr_en;
        logic scan_run;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_entry;

    function automatic logic signed [Q_W-1:0] coord_to_q(input logic signed [COORD_W-1:0] v);
        return Q_W'(v);
    endfunction

    function automatic logic signed [Q_W-1:0] size_to_q(input logic [SIZE_W-1:0] s);
        return Q_W'({s, 4'b0000});
    endfunction

endpackage

FILE: hw/rtl/box_overlap_first_hit_search.sv
// A slot write goes through WRITE to RESULT; an unused mode goes straight to RESULT.
// A query scans the table and stops at the first slot that hits; a miss scans all MAX_BOXES
// slots, one table read and one compare per slot. RESULT waits while the output is stalled.
// A new input beat is taken in the cycle after a result is loaded into the output register.
// Reset is synchronous and active low; it marks every table slot invalid at once.
// ----------------------------------------------------------------------------
// Box overlap first-hit search
// Table of object boxes with slot writes and a first-hit overlap query that
// walks the table in index order.
// ----------------------------------------------------------------------------
module box_overlap_first_hit_search (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_mode,
    input  logic [boxov_pkg::SLOT_W-1:0]           i_slot,
    input  logic                                   i_slot_valid,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_x_a,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_y_a,
    input  logic [boxov_pkg::SIZE_W-1:0]           i_box_width,
    input  logic [boxov_pkg::SIZE_W-1:0]           i_box_height,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_x_b,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_y_b,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_hit,
    output logic [boxov_pkg::SLOT_W-1:0]           o_hit_slot
);
    import boxov_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    boxov_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    boxov_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_slot_valid (i_slot_valid),
        .i_x_a        (i_x_a),
        .i_y_a        (i_y_a),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_x_b        (i_x_b),
        .i_y_b        (i_y_b),
        .o_hit        (o_hit),
        .o_hit_slot   (o_hit_slot)
    );

endmodule

FILE: hw/rtl/boxov_ctrl.sv
// ----------------------------------------------------------------------------
// Box overlap search controller
// Sequences slot writes and table scans and runs the output handshake.
// ----------------------------------------------------------------------------
module boxov_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_mode,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  boxov_pkg::t_dp_sts  i_sts,
    output boxov_pkg::t_dp_cmd  o_cmd
);
    import boxov_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WRITE  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_o_valid;
    logic   n_o_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state        = r_state;
        n_o_valid      = r_o_valid && i_stall;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_mode == MODE_WRITE) begin
                        n_state = ST_WRITE;
                    end else if (i_mode inside {MODE_QPOS, MODE_QBND}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state     = ST_RESULT;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_o_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;

endmodule

FILE: hw/rtl/boxov_dp.sv
// ----------------------------------------------------------------------------
// Box overlap search datapath
// Holds the box table, the captured item, the scan pipeline with its overlap
// compare, and the result registers.
// ----------------------------------------------------------------------------
module boxov_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  boxov_pkg::t_dp_cmd                     i_cmd,
    output boxov_pkg::t_dp_sts                     o_sts,
    input  logic [1:0]                             i_mode,
    input  logic [boxov_pkg::SLOT_W-1:0]           i_slot,
    input  logic                                   i_slot_valid,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_x_a,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_y_a,
    input  logic [boxov_pkg::SIZE_W-1:0]           i_box_width,
    input  logic [boxov_pkg::SIZE_W-1:0]           i_box_height,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_x_b,
    input  logic signed [boxov_pkg::COORD_W-1:0]   i_y_b,
    output logic                                   o_hit,
    output logic [boxov_pkg::SLOT_W-1:0]           o_hit_slot
);
    import boxov_pkg::*;

    t_entry                 r_mem [MAX_BOXES];
    logic [MAX_BOXES-1:0]   r_valid;

    logic [SLOT_W-1:0]      r_slot;
    logic                   r_slot_valid;
    t_entry                 r_item;
    logic signed [Q_W-1:0]  r_qxmin;
    logic signed [Q_W-1:0]  r_qxmax;
    logic signed [Q_W-1:0]  r_qymin;
    logic signed [Q_W-1:0]  r_qymax;

    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_more;
    t_entry                 r_rd_data;
    logic                   r_pact;
    logic                   r_pv;
    logic                   r_plast;
    logic [IDX_W-1:0]       r_pidx;

    logic                   r_res_hit;
    logic [SLOT_W-1:0]      r_res_slot;
    logic                   r_o_hit;
    logic [SLOT_W-1:0]      r_o_hit_slot;

    logic [CMP_W-1:0]       wr_slot_ext;
    logic                   wr_in_range;
    logic [IDX_W-1:0]       wr_idx;
    logic [CMP_W-1:0]       pidx_ext;
    logic                   issue;
    logic signed [Q_W-1:0]  e_x0;
    logic signed [Q_W-1:0]  e_x1;
    logic signed [Q_W-1:0]  e_y0;
    logic signed [Q_W-1:0]  e_y1;
    logic                   overlap;
    logic                   match;

    assign wr_slot_ext = CMP_W'(r_slot);
    assign wr_in_range = wr_slot_ext < CMP_W'(MAX_BOXES);
    assign wr_idx      = wr_slot_ext[IDX_W-1:0];
    assign pidx_ext    = CMP_W'(r_pidx);
    assign issue       = i_cmd.scan_run && r_rd_more;

    assign e_x0    = coord_to_q(r_rd_data.x);
    assign e_x1    = e_x0 + size_to_q(r_rd_data.w);
    assign e_y0    = coord_to_q(r_rd_data.y);
    assign e_y1    = e_y0 + size_to_q(r_rd_data.h);
    assign overlap = (e_x0 < r_qxmax) && (e_x1 > r_qxmin)
                  && (e_y0 < r_qymax) && (e_y1 > r_qymin);
    assign match   = r_pact && r_pv && overlap;

    assign o_sts.scan_done = match || (r_pact && r_plast);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot       <= i_slot;
            r_slot_valid <= i_slot_valid;
            r_item.x     <= i_x_a;
            r_item.y     <= i_y_a;
            r_item.w     <= i_box_width;
            r_item.h     <= i_box_height;
            r_qxmin      <= coord_to_q(i_x_a);
            r_qymin      <= coord_to_q(i_y_a);
            if (i_mode == MODE_QPOS) begin
                r_qxmax <= coord_to_q(i_x_a) + size_to_q(i_box_width);
                r_qymax <= coord_to_q(i_y_a) + size_to_q(i_box_height);
            end else begin
                r_qxmax <= coord_to_q(i_x_b);
                r_qymax <= coord_to_q(i_y_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[wr_idx] <= r_item;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_more <= 1'b0;
            r_pact    <= 1'b0;
        end else begin
            if (i_cmd.wr_en && wr_in_range) begin
                r_valid[wr_idx] <= r_slot_valid;
            end
            if (i_cmd.capture) begin
                r_rd_more <= 1'b1;
                r_pact    <= 1'b0;
            end else begin
                r_pact <= issue;
                if (issue && (r_rd_idx == IDX_W'(MAX_BOXES - 1))) begin
                    r_rd_more <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_idx   <= '0;
            r_res_hit  <= 1'b0;
            r_res_slot <= '0;
        end else begin
            if (issue) begin
                r_pv    <= r_valid[r_rd_idx];
                r_plast <= (r_rd_idx == IDX_W'(MAX_BOXES - 1));
                r_pidx  <= r_rd_idx;
                if (r_rd_idx != IDX_W'(MAX_BOXES - 1)) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (i_cmd.scan_run && match) begin
                r_res_hit  <= 1'b1;
                r_res_slot <= pidx_ext[SLOT_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_o_hit      <= r_res_hit;
            r_o_hit_slot <= r_res_slot;
        end
    end

    assign o_hit      = r_o_hit;
    assign o_hit_slot = r_o_hit_slot;

endmodule

FILE: hw/rtl/boxov_checker.sv
// ----------------------------------------------------------------------------
// Box overlap search checker
// Port-level assertions on the box overlap first-hit search, bound to the
// top level.
// ----------------------------------------------------------------------------
module boxov_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic                           o_hit,
    input  logic [boxov_pkg::SLOT_W-1:0]   o_hit_slot
);
    import boxov_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_hit_slot))
        else $error("Output beat changed while stalled.");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_slot == '0)
        else $error("Result without a hit carries a nonzero slot.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !($rose(o_valid)))
        else $error("Block not busy in the cycle after an input beat.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Reset did not clear the handshake.");

endmodule

bind box_overlap_first_hit_search boxov_checker u_boxov_checker (.*);
